// File: design/earenv_pkg.sv
// Shared definitions for the exponential attack/release envelope:
// request and gate codes, register map, default fixed-point format and reset values.
// No dependencies.
package earenv_pkg;

    // Fixed-point fraction bits of the default format (1.0 = 2^FRAC_BITS_DEF)
    localparam int FRAC_BITS_DEF = 23;

    // APB address bits: four 32-bit registers at byte offsets 0, 4, 8, 12
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Reset values given in the default Q1.23 format
    localparam int                RST_REF_FRAC       = 23;
    localparam longint unsigned   ATTACK_MULT_RST    = 64'd8300000;
    localparam longint unsigned   ATTACK_ADD_RST     = 64'd100000;
    localparam longint unsigned   RELEASE_MULT_RST   = 64'd8300000;
    localparam longint unsigned   RELEASE_SCALE_RMAG = 64'd100000;  // value is negative

    typedef enum logic {
        REQ_TICK = 1'b0,
        REQ_GATE = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        GATE_OFF     = 2'd0,
        GATE_ON      = 2'd1,
        GATE_ON_ZERO = 2'd2
    } t_gate_code;

    typedef enum logic [1:0] {
        REG_ATTACK_MULT   = 2'd0,
        REG_ATTACK_ADD    = 2'd1,
        REG_RELEASE_MULT  = 2'd2,
        REG_RELEASE_SCALE = 2'd3
    } t_reg_idx;

    // Rescale a Q1.23 reset constant to another fraction width
    function automatic longint unsigned rst_scale(input longint unsigned v, input int frac);
        if (frac >= RST_REF_FRAC) begin
            return v << (frac - RST_REF_FRAC);
        end else begin
            return v >> (RST_REF_FRAC - frac);
        end
    endfunction

endpackage

// File: design/earenv_req_if.sv
// Request channel of the envelope: valid/ready plus one input item
// (request type and gate code). Uses earenv_pkg for the field types.
interface earenv_req_if;
    logic                   valid;
    logic                   ready;
    earenv_pkg::t_req_type  req_type;
    logic [1:0]             gate_code;

    modport source (output valid, output req_type, output gate_code, input ready);
    modport sink   (input valid, input req_type, input gate_code, output ready);
endinterface

// File: design/earenv_lvl_if.sv
// Result channel of the envelope: valid/ready plus the level of one item.
// Width follows the fixed-point format from earenv_pkg.
interface earenv_lvl_if #(
    parameter int LEVEL_W = earenv_pkg::FRAC_BITS_DEF + 1
);
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

// File: design/earenv_cfg_regs.sv
// APB configuration registers of the envelope: attack/release coefficients.
// Depends on earenv_pkg for the register map and reset values.
module earenv_cfg_regs #(
    parameter int FRAC_BITS = earenv_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [earenv_pkg::ADDR_W-1:0] paddr,
    input  logic [earenv_pkg::DATA_W-1:0] pwdata,
    output logic [earenv_pkg::DATA_W-1:0] prdata,
    output logic                          pready,
    output logic [FRAC_BITS-1:0]          o_attack_mult,
    output logic [FRAC_BITS-1:0]          o_attack_add,
    output logic [FRAC_BITS-1:0]          o_release_mult,
    output logic signed [FRAC_BITS:0]     o_release_scale
);

    localparam logic [FRAC_BITS-1:0] AM_RST =
        FRAC_BITS'(earenv_pkg::rst_scale(earenv_pkg::ATTACK_MULT_RST, FRAC_BITS));
    localparam logic [FRAC_BITS-1:0] AA_RST =
        FRAC_BITS'(earenv_pkg::rst_scale(earenv_pkg::ATTACK_ADD_RST, FRAC_BITS));
    localparam logic [FRAC_BITS-1:0] RM_RST =
        FRAC_BITS'(earenv_pkg::rst_scale(earenv_pkg::RELEASE_MULT_RST, FRAC_BITS));
    localparam logic [FRAC_BITS:0] RS_RST =
        (FRAC_BITS+1)'(64'd0 - earenv_pkg::rst_scale(earenv_pkg::RELEASE_SCALE_RMAG, FRAC_BITS));

    logic                     wr_en;
    earenv_pkg::t_reg_idx     reg_idx;
    logic [FRAC_BITS-1:0]     r_attack_mult;
    logic [FRAC_BITS-1:0]     r_attack_add;
    logic [FRAC_BITS-1:0]     r_release_mult;
    logic [FRAC_BITS:0]       r_release_scale;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = earenv_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_mult   <= AM_RST;
            r_attack_add    <= AA_RST;
            r_release_mult  <= RM_RST;
            r_release_scale <= RS_RST;
        end else if (wr_en) begin
            case (reg_idx)
                earenv_pkg::REG_ATTACK_MULT:   r_attack_mult   <= pwdata[FRAC_BITS-1:0];
                earenv_pkg::REG_ATTACK_ADD:    r_attack_add    <= pwdata[FRAC_BITS-1:0];
                earenv_pkg::REG_RELEASE_MULT:  r_release_mult  <= pwdata[FRAC_BITS-1:0];
                earenv_pkg::REG_RELEASE_SCALE: r_release_scale <= pwdata[FRAC_BITS:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            earenv_pkg::REG_ATTACK_MULT:
                prdata = earenv_pkg::DATA_W'(r_attack_mult);
            earenv_pkg::REG_ATTACK_ADD:
                prdata = earenv_pkg::DATA_W'(r_attack_add);
            earenv_pkg::REG_RELEASE_MULT:
                prdata = earenv_pkg::DATA_W'(r_release_mult);
            earenv_pkg::REG_RELEASE_SCALE:
                prdata = earenv_pkg::DATA_W'($signed(r_release_scale));
            default:
                prdata = '0;
        endcase
    end

    assign o_attack_mult   = r_attack_mult;
    assign o_attack_add    = r_attack_add;
    assign o_release_mult  = r_release_mult;
    assign o_release_scale = $signed(r_release_scale);

endmodule

// File: design/exp_attack_release_envelope.sv
// Gated exponential attack/release envelope, top level.
// Depends on earenv_pkg, earenv_req_if, earenv_lvl_if and earenv_cfg_regs.
//
// Usage:
//   i_req carries items: a sample tick (req_type = REQ_TICK) or a gate event
//   (req_type = REQ_GATE with gate_code off / on / on-with-zero). Gate events
//   produce no result; each tick produces one item on o_lvl holding the
//   level before that tick's update (Q1.FRAC_BITS, full scale = 2^FRAC_BITS).
//   Coefficients are written over the APB port (registers at 0x0, 0x4, 0x8,
//   0xC); pready is always high. The user must write them only while the
//   block is idle; the block itself does not enforce this. An accepted item
//   waits in the input register until it advances into the state/output
//   registers. Throughput: one item per cycle unless a tick waits on a
//   stalled o_lvl; each item takes one pass through the multiply-add-clamp
//   between the input register and the state/output registers.
//   When o_lvl stalls, the finished level waits in the output register and
//   one more item is held in the input register; gate events keep flowing
//   past a stalled result. i_req.ready drops only once both are full.
//   Reset (synchronous, active low) clears level, gate and release offset,
//   empties both registers and loads the default coefficients.
module exp_attack_release_envelope #(
    parameter int FRAC_BITS = earenv_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    earenv_req_if.sink                    i_req,
    earenv_lvl_if.source                  o_lvl,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [earenv_pkg::ADDR_W-1:0] paddr,
    input  logic [earenv_pkg::DATA_W-1:0] pwdata,
    output logic [earenv_pkg::DATA_W-1:0] prdata,
    output logic                          pready
);

    localparam int LW = FRAC_BITS + 1;            // level width, holds 1.0
    localparam logic [LW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [FRAC_BITS-1:0]      attack_mult;
    logic [FRAC_BITS-1:0]      attack_add;
    logic [FRAC_BITS-1:0]      release_mult;
    logic signed [FRAC_BITS:0] release_scale;

    earenv_cfg_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_attack_mult   (attack_mult),
        .o_attack_add    (attack_add),
        .o_release_mult  (release_mult),
        .o_release_scale (release_scale)
    );

    // Input register
    logic                   r_in_vld;
    earenv_pkg::t_req_type  r_in_type;
    logic [1:0]             r_in_code;

    // Envelope state
    logic [LW-1:0]          r_level;
    logic [LW-1:0]          n_level;
    logic                   r_gate;
    logic                   n_gate;
    logic signed [LW:0]     r_offset;
    logic signed [LW:0]     n_offset;

    // Output register
    logic                   r_out_vld;
    logic [LW-1:0]          r_out_level;

    logic                   advance;
    logic                   is_tick;

    assign is_tick = (r_in_type == earenv_pkg::REQ_TICK);
    assign advance = r_in_vld && (!is_tick || !r_out_vld || o_lvl.ready);
    assign i_req.ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_type <= i_req.req_type;
            r_in_code <= i_req.gate_code;
        end
    end

    // Attack step: level*attack_mult >> F + attack_add, clamped at 1.0
    logic [2*FRAC_BITS:0]   atk_prod;
    logic [LW:0]            atk_sum;
    logic [LW-1:0]          atk_level;

    assign atk_prod = r_level * attack_mult;
    assign atk_sum  = {1'b0, atk_prod[2*FRAC_BITS:FRAC_BITS]} + {2'b00, attack_add};

    always_comb begin
        if (r_level >= ONE || atk_sum >= {1'b0, ONE}) begin
            atk_level = ONE;
        end else begin
            atk_level = atk_sum[LW-1:0];
        end
    end

    // Release step: level*release_mult >> F + offset, clamped to [0, 1.0]
    logic [2*FRAC_BITS:0]   rel_prod;
    logic signed [LW+1:0]   rel_sum;
    logic [LW-1:0]          rel_level;

    assign rel_prod = r_level * release_mult;
    assign rel_sum  = $signed({2'b00, rel_prod[2*FRAC_BITS:FRAC_BITS]})
                      + $signed({r_offset[LW], r_offset});

    always_comb begin
        if (r_level == '0 || rel_sum[LW+1] || rel_sum == '0) begin
            rel_level = '0;
        end else if (rel_sum[LW:0] > {1'b0, ONE}) begin
            rel_level = ONE;
        end else begin
            rel_level = rel_sum[LW-1:0];
        end
    end

    // Release offset at gate-off: sign(scale) * ((level * |scale|) >> F)
    logic [LW-1:0]          scale_mag;
    logic [2*LW-1:0]        off_prod;
    logic [LW:0]            off_mag;
    logic signed [LW:0]     off_new;

    assign scale_mag = release_scale[FRAC_BITS] ? LW'(-release_scale) : LW'(release_scale);
    assign off_prod  = r_level * scale_mag;
    assign off_mag   = off_prod[2*LW-1:FRAC_BITS];
    assign off_new   = release_scale[FRAC_BITS] ? -$signed(off_mag) : $signed(off_mag);

    always_comb begin
        n_level  = r_level;
        n_gate   = r_gate;
        n_offset = r_offset;
        if (advance) begin
            if (is_tick) begin
                n_level = r_gate ? atk_level : rel_level;
            end else begin
                case (earenv_pkg::t_gate_code'(r_in_code))
                    earenv_pkg::GATE_OFF: begin
                        if (r_gate) begin
                            n_gate   = 1'b0;
                            n_offset = off_new;
                        end
                    end
                    earenv_pkg::GATE_ON_ZERO: begin
                        n_gate  = 1'b1;
                        n_level = '0;
                    end
                    earenv_pkg::GATE_ON: begin
                        n_gate = 1'b1;
                    end
                    default: begin
                        // unused code acts as a plain gate-on
                        n_gate = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= '0;
            r_gate   <= 1'b0;
            r_offset <= '0;
        end else begin
            r_level  <= n_level;
            r_gate   <= n_gate;
            r_offset <= n_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance && is_tick) begin
            r_out_vld <= 1'b1;
        end else if (o_lvl.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && is_tick) begin
            r_out_level <= r_level;
        end
    end

    assign o_lvl.valid = r_out_vld;
    assign o_lvl.level = r_out_level;

endmodule

// File: bench/earenv_level_checker.sv
`timescale 1ns / 100ps
// Level checker for the attack/release envelope: watches the request, result and
// register-write traffic, predicts every tick's level and compares it with the result's level.
// Depends on earenv_pkg, earenv_req_if and earenv_lvl_if.
module earenv_level_checker
    import earenv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    earenv_req_if             i_req,
    earenv_lvl_if             i_lvl,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    output int                o_fail_cnt,
    output int                o_pending
);

    typedef longint unsigned u64_t;
    typedef longint          s64_t;

    localparam int   FB   = FRAC_BITS_DEF;
    localparam u64_t FULL = u64_t'(1) << FB;

    // predicted coefficients and envelope state
    logic [22:0]        cfg_amul;
    logic [22:0]        cfg_aadd;
    logic [22:0]        cfg_rmul;
    logic signed [23:0] cfg_rscale;
    logic [23:0]        env_lvl;
    logic               env_open;
    logic signed [24:0] env_roff;

    logic [23:0] level_q[$];
    int          fail_cnt;

    // level after one tick
    function automatic u64_t advanced_level();
        u64_t lvl;
        u64_t up;
        s64_t down;
        lvl = u64_t'(env_lvl);
        if (env_open) begin
            if (lvl >= FULL) begin
                return FULL;
            end
            up = ((lvl * u64_t'(cfg_amul)) >> FB) + u64_t'(cfg_aadd);
            return (up >= FULL) ? FULL : up;
        end
        if (lvl == 0) begin
            return 0;
        end
        down = s64_t'((lvl * u64_t'(cfg_rmul)) >> FB) + s64_t'(env_roff);
        if (down <= 0) begin
            return 0;
        end
        if (u64_t'(down) > FULL) begin
            return FULL;
        end
        return u64_t'(down);
    endfunction

    // offset taken at gate-off: magnitude truncated, then the sign applied
    function automatic s64_t offset_at_release();
        u64_t lvl;
        u64_t mag;
        s64_t rs;
        lvl = u64_t'(env_lvl);
        rs  = s64_t'(cfg_rscale);
        if (rs < 0) begin
            mag = (lvl * u64_t'(-rs)) >> FB;
            return -s64_t'(mag);
        end
        mag = (lvl * u64_t'(rs)) >> FB;
        return s64_t'(mag);
    endfunction

    always @(posedge i_clk) begin
        logic [23:0] want;
        if (!i_rst_n) begin
            cfg_amul   = 23'(ATTACK_MULT_RST);
            cfg_aadd   = 23'(ATTACK_ADD_RST);
            cfg_rmul   = 23'(RELEASE_MULT_RST);
            cfg_rscale = -$signed(24'(RELEASE_SCALE_RMAG));
            env_lvl    = '0;
            env_open   = 1'b0;
            env_roff   = '0;
            level_q.delete();
            fail_cnt   = 0;
        end else begin
            // results leave before this edge's item is predicted
            if (i_lvl.valid && i_lvl.ready) begin
                if (level_q.size() == 0) begin
                    $error("level: unexpected item, actual %0d", i_lvl.level);
                    fail_cnt++;
                end else begin
                    want = level_q.pop_front();
                    if (i_lvl.level !== want) begin
                        $error("level mismatch: expected %0d, actual %0d", want, i_lvl.level);
                        fail_cnt++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                if (i_req.req_type == REQ_TICK) begin
                    level_q.push_back(env_lvl);
                    env_lvl = 24'(advanced_level());
                end else begin
                    case (i_req.gate_code)
                        GATE_OFF: begin
                            if (env_open) begin
                                env_open = 1'b0;
                                env_roff = 25'(offset_at_release());
                            end
                        end
                        GATE_ON_ZERO: begin
                            env_open = 1'b1;
                            env_lvl  = '0;
                        end
                        // plain gate-on, and the spare code acts the same
                        default: env_open = 1'b1;
                    endcase
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_ATTACK_MULT:   cfg_amul   = pwdata[22:0];
                    REG_ATTACK_ADD:    cfg_aadd   = pwdata[22:0];
                    REG_RELEASE_MULT:  cfg_rmul   = pwdata[22:0];
                    REG_RELEASE_SCALE: cfg_rscale = pwdata[23:0];
                    default: ;
                endcase
            end
        end
        o_fail_cnt <= fail_cnt;
        o_pending  <= level_q.size();
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for exp_attack_release_envelope: clock, reset, register writes,
// bursty request stimulus and a stalling result sink; earenv_level_checker checks.
// Depends on earenv_pkg, earenv_req_if, earenv_lvl_if and the block itself.
module tb_top;
    import earenv_pkg::*;

    localparam logic [1:0] GATE_CODE_SPARE = 2'd3;
    localparam int         SETTLE_CYCLES   = 4;
    localparam int         QUIET_LIMIT     = 2000;
    localparam int         PHASES          = 8;
    localparam int         PHASE_ITEMS     = 125;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    earenv_req_if req_ch ();
    earenv_lvl_if lvl_ch ();

    int fail_cnt;
    int pending;
    int burst_left = 0;
    int stall_left;
    int quiet_cycles;

    always #5 i_clk = ~i_clk;

    exp_attack_release_envelope uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_lvl   (lvl_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    earenv_level_checker level_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .i_lvl      (lvl_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    // result sink: segments of steady ready, short and long stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lvl_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else if (stall_left == 0) begin
            case ($urandom_range(0, 3))
                0: begin
                    lvl_ch.ready <= 1'b1;
                    stall_left   <= $urandom_range(50, 200);
                end
                1: begin
                    lvl_ch.ready <= 1'b1;
                    stall_left   <= $urandom_range(0, 7);
                end
                2: begin
                    lvl_ch.ready <= 1'b0;
                    stall_left   <= $urandom_range(0, 2);
                end
                default: begin
                    lvl_ch.ready <= 1'b0;
                    stall_left   <= $urandom_range(3, 11);
                end
            endcase
        end else begin
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (lvl_ch.valid && lvl_ch.ready)
                || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one item, with a random gap in front of each burst
    task automatic send_item(input t_req_type rt, input logic [1:0] gc);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) begin
                    req_ch.req_type  <= t_req_type'($urandom_range(0, 1));
                    req_ch.gate_code <= 2'($urandom_range(0, 3));
                    @(posedge i_clk);
                end
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= rt;
        req_ch.gate_code <= gc;
        @(posedge i_clk);
        while (!req_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_tick();
        send_item(REQ_TICK, 2'($urandom_range(0, 3)));
    endtask

    // hold off until every level has come out, then let gate events settle
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) begin
            @(posedge i_clk);
        end
    endtask

    task automatic reg_write(input t_reg_idx idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_config(input logic [31:0] am, input logic [31:0] aa,
                                input logic [31:0] rm, input logic [31:0] rs);
        reg_write(REG_ATTACK_MULT, am);
        reg_write(REG_ATTACK_ADD, aa);
        reg_write(REG_RELEASE_MULT, rm);
        reg_write(REG_RELEASE_SCALE, rs);
    endtask

    // half the time fill the bits above the register with noise
    function automatic logic [31:0] with_junk(input logic [31:0] v, input int w);
        logic [31:0] hi;
        hi = $urandom();
        if ($urandom_range(0, 1) == 0) begin
            return v;
        end
        return (v & ((32'd1 << w) - 1)) | (hi << w);
    endfunction

    task automatic random_config();
        logic [31:0] am;
        logic [31:0] aa;
        logic [31:0] rm;
        logic [31:0] rs;
        case ($urandom_range(0, 4))
            0:       am = 32'd0;
            1:       am = 32'h007F_FFFF;
            4:       am = $urandom_range(0, 8388607);
            default: am = $urandom_range(7000000, 8388607);
        endcase
        case ($urandom_range(0, 4))
            0:       aa = 32'd0;
            1:       aa = 32'h007F_FFFF;
            4:       aa = $urandom_range(0, 8388607);
            default: aa = $urandom_range(1, 300000);
        endcase
        case ($urandom_range(0, 4))
            0:       rm = 32'd0;
            1:       rm = 32'h007F_FFFF;
            4:       rm = $urandom_range(0, 8388607);
            default: rm = $urandom_range(7000000, 8388607);
        endcase
        case ($urandom_range(0, 5))
            0:       rs = 32'hFF80_0000;
            1:       rs = 32'd0;
            2:       rs = $urandom_range(1, 8388607);
            5:       rs = $urandom();
            default: rs = -$urandom_range(1, 400000);
        endcase
        write_config(with_junk(am, 23), with_junk(aa, 23), with_junk(rm, 23), with_junk(rs, 24));
    endtask

    function automatic int run_length();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(30, 250) : $urandom_range(0, 30);
    endfunction

    initial begin
        int         sent;
        int         ticks;
        logic [1:0] on_code;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= REQ_TICK;
        req_ch.gate_code <= GATE_OFF;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        i_rst_n          <= 1'b0;
        repeat (8) begin
            @(posedge i_clk);
        end
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default coefficients: closed-gate ticks, repeated gate-on, zeroing, spare code
        send_tick();
        send_item(REQ_GATE, GATE_OFF);
        send_item(REQ_GATE, GATE_ON);
        repeat (3) send_tick();
        send_item(REQ_GATE, GATE_ON);
        send_tick();
        send_item(REQ_GATE, GATE_ON_ZERO);
        repeat (2) send_tick();
        send_item(REQ_GATE, GATE_CODE_SPARE);
        send_tick();
        send_item(REQ_GATE, GATE_OFF);
        repeat (3) send_tick();
        send_item(REQ_GATE, GATE_OFF);
        send_tick();
        drain_results();

        // attack up to full scale and held, then the deepest release down to zero
        write_config(32'h007F_FFFF, 32'h007F_FFFF, 32'd0, 32'hFF80_0000);
        send_item(REQ_GATE, GATE_ON);
        repeat (3) send_tick();
        send_item(REQ_GATE, GATE_OFF);
        repeat (2) send_tick();
        drain_results();

        // positive scale drives the release past full scale; junk above the fields
        write_config(32'hFF80_0000, 32'hFFFF_FFFF, 32'h007F_FFFF, 32'hAB7F_FFFF);
        send_item(REQ_GATE, GATE_ON);
        repeat (2) send_tick();
        send_item(REQ_GATE, GATE_OFF);
        repeat (2) send_tick();
        drain_results();

        for (int phase = 0; phase < PHASES; phase++) begin
            random_config();
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 8) begin
                    case ($urandom_range(0, 5))
                        3, 4:    on_code = GATE_ON_ZERO;
                        5:       on_code = GATE_CODE_SPARE;
                        default: on_code = GATE_ON;
                    endcase
                    send_item(REQ_GATE, on_code);
                    ticks = run_length();
                    repeat (ticks) send_tick();
                    sent += ticks + 1;
                    send_item(REQ_GATE, GATE_OFF);
                    ticks = run_length();
                    repeat (ticks) send_tick();
                    sent += ticks + 1;
                end else begin
                    send_item(t_req_type'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
                    sent++;
                end
                if ($urandom_range(0, 29) == 0) begin
                    drain_results();
                end
            end
            drain_results();
        end

        if (fail_cnt == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
design/earenv_pkg.sv
design/earenv_req_if.sv
design/earenv_lvl_if.sv
design/earenv_cfg_regs.sv
design/exp_attack_release_envelope.sv
bench/earenv_level_checker.sv
bench/tb_top.sv
